// ===== rtl/vst_pkg.sv =====
// Shared types, sizes and codes for the value set table.
package vst_pkg;

    // Table size and the widths that follow from it
    localparam int CAPACITY = 128;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    // Operation codes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;  // unused code, table left alone

    // Status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    // Input word
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic       found;
        logic [1:0] status;
        logic [7:0] count;
    } t_out_word;

    // Finished result from the sequencer
    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_res;

    // Memory access request from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [31:0]       wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

// ===== rtl/value_set_table_unit.sv =====
// Top level of the value set table: sequencer, entry memory, output register.
//
//  channel | direction | valid       | stall       | word
//  --------+-----------+-------------+-------------+-----------------------
//  in      | input     | i_in_valid  | o_in_stall  | i_in_word (mode,value)
//  out     | output    | o_out_valid | i_out_stall | o_out_word (found,status,count)
//
// Each word is a scan of the stored entries, one memory read per entry, then the
// registered read data and a finish state; lookup and insert stop at the first hit,
// and a no-op mode skips the scan. The single read port of the entry memory sets this.
// Reset clears the entry count and control state; the memory keeps its contents, and
// no clearing pass is run. A stalled output holds its word in the output register; a
// finished word waits in the sequencer only while that register is full and stalled.
module value_set_table_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  vst_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output vst_pkg::t_out_word o_out_word
);
    import vst_pkg::*;

    logic        w_idle;
    logic        w_start;
    logic        w_slot_free;
    logic [31:0] w_rd_data;
    t_ram_req    w_ram;
    t_res        w_res;

    logic        r_out_valid, n_out_valid;
    t_out_word   r_out_word, n_out_word;

    assign o_in_stall  = !w_idle;
    assign w_start     = i_in_valid && w_idle;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    vst_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_word      (i_in_word),
        .i_res_ready (w_slot_free),
        .i_rd_data   (w_rd_data),
        .o_idle      (w_idle),
        .o_ram       (w_ram),
        .o_res       (w_res)
    );

    vst_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rd_data)
    );

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        if (w_res.valid && w_slot_free) begin
            n_out_valid = 1'b1;
            n_out_word  = w_res.word;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // a dropped insert only happens with the table at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.valid && w_res.word.status == ST_FULL) |-> (w_res.word.count == 8'(CAPACITY)))
        else $error("full status with count below capacity");

    // a failed remove never reports a match
    a_missing_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.valid && w_res.word.status == ST_MISSING) |-> !w_res.word.found)
        else $error("missing status with found set");

    // a new output word comes only from a finished sequencer result
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_res.valid))
        else $error("output word without a finished result");

    // the sequencer offers no result while it is ready for input
    a_idle_nores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_res.valid)
        else $error("result offered while idle");

endmodule

// ===== rtl/vst_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module vst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vst_seq.sv =====
// Sequencer: scans the entry memory, shifts on remove, appends on insert.
module vst_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  vst_pkg::t_in_word i_word,
    input  logic              i_res_ready,
    input  logic [31:0]       i_rd_data,
    output logic              o_idle,
    output vst_pkg::t_ram_req o_ram,
    output vst_pkg::t_res     o_res
);
    import vst_pkg::*;

    t_state             r_state, n_state;
    logic [1:0]         r_mode, n_mode;
    logic [31:0]        r_value, n_value;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_ptr, n_ptr;
    logic               r_pend, n_pend;
    logic [ADDR_W-1:0]  r_pend_addr, n_pend_addr;
    logic               r_hit, n_hit;

    logic issue;
    logic match;
    logic room;

    assign issue = (r_ptr < r_count);
    assign match = r_pend && !r_hit && (i_rd_data == r_value);
    assign room  = (r_count < COUNT_W'(CAPACITY));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_word.mode == MODE_NOP) ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                // stop at the first hit unless entries must shift down
                if ((match && r_mode != MODE_REMOVE) || !issue) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory requests and result
    always_comb begin
        n_mode      = r_mode;
        n_value     = r_value;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_hit       = r_hit;
        o_ram.we    = 1'b0;
        o_ram.waddr = r_pend_addr - ADDR_W'(1);
        o_ram.wdata = i_rd_data;
        o_ram.raddr = r_ptr[ADDR_W-1:0];
        o_res.valid       = 1'b0;
        o_res.word.found  = r_hit;
        o_res.word.status = ST_DONE;
        o_res.word.count  = 8'(r_count);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_mode  = i_word.mode;
                    n_value = i_word.value;
                    n_ptr   = '0;
                    n_pend  = 1'b0;
                    n_hit   = 1'b0;
                end
            end
            S_SCAN: begin
                // stream reads; data of address k lands in the next cycle
                n_pend      = issue;
                n_pend_addr = r_ptr[ADDR_W-1:0];
                if (issue) begin
                    n_ptr = r_ptr + COUNT_W'(1);
                end
                if (match) begin
                    n_hit = 1'b1;
                end
                // after the hit, each later entry moves down one place
                if (r_pend && r_hit && r_mode == MODE_REMOVE) begin
                    o_ram.we = 1'b1;
                end
            end
            S_FINISH: begin
                o_res.valid = 1'b1;
                case (r_mode)
                    MODE_INSERT: begin
                        o_ram.waddr = r_count[ADDR_W-1:0];
                        o_ram.wdata = r_value;
                        if (room) begin
                            o_res.word.count = 8'(r_count + COUNT_W'(1));
                            if (i_res_ready) begin
                                o_ram.we = 1'b1;
                                n_count  = r_count + COUNT_W'(1);
                            end
                        end else begin
                            o_res.word.status = ST_FULL;
                        end
                    end
                    MODE_REMOVE: begin
                        if (r_hit) begin
                            o_res.word.count = 8'(r_count - COUNT_W'(1));
                            if (i_res_ready) begin
                                n_count = r_count - COUNT_W'(1);
                            end
                        end else begin
                            o_res.word.status = ST_MISSING;
                        end
                    end
                    MODE_LOOKUP: begin
                    end
                    default: begin
                        o_res.word.found = 1'b0;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_hit   <= n_hit;
        end
        r_mode      <= n_mode;
        r_value     <= n_value;
        r_ptr       <= n_ptr;
        r_pend_addr <= n_pend_addr;
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// ===== sim/value_set_checker.sv =====
// Checker for the value set table: shadow table, word prediction and compare.
module value_set_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  vst_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  vst_pkg::t_out_word i_out_word,
    output int                 o_fail_count,
    output int                 o_pending
);
    import vst_pkg::*;

    // Shadow table in insertion order, and the words still owed by the block
    logic [31:0] stored_values[$];
    t_out_word   expected_words[$];
    int          mismatch_count = 0;

    // Apply one operation to the shadow table and return the word it should produce
    function automatic t_out_word predict_table_op(t_in_word w);
        t_out_word r;
        int        pos;
        pos      = -1;
        r.found  = 1'b0;
        r.status = ST_DONE;
        if (w.mode <= MODE_LOOKUP) begin
            // first equal entry, raw bit compare
            foreach (stored_values[i]) begin
                if (pos < 0 && stored_values[i] == w.value) pos = i;
            end
            r.found = (pos >= 0);
            if (w.mode == MODE_INSERT) begin
                if (stored_values.size() < CAPACITY) stored_values.push_back(w.value);
                else r.status = ST_FULL;
            end else if (w.mode == MODE_REMOVE) begin
                // delete shifts the later entries down
                if (pos >= 0) stored_values.delete(pos);
                else r.status = ST_MISSING;
            end
        end
        r.count = 8'(stored_values.size());
        return r;
    endfunction

    // Outputs are handled before inputs: a word leaving now can't belong to one entering now
    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            expected_words.delete();
            stored_values.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: found=%0b status=%0d count=%0d",
                                 i_out_word.found, i_out_word.status, i_out_word.count);
                end else begin
                    want = expected_words.pop_front();
                    if (i_out_word.found !== want.found ||
                        i_out_word.status !== want.status ||
                        i_out_word.count !== want.count) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"word mismatch: exp found=%0b status=%0d count=%0d,",
                                      " got found=%0b status=%0d count=%0d"},
                                     want.found, want.status, want.count,
                                     i_out_word.found, i_out_word.status,
                                     i_out_word.count);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(predict_table_op(i_in_word));
        end
        // registered so the stimulus side samples it without a race
        o_pending <= expected_words.size();
    end

    assign o_fail_count = mismatch_count;

endmodule

// ===== sim/tb.sv =====
// Testbench top for the value set table: clock, reset, stimulus, receiver stalls and verdict.
module tb;
    import vst_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD  = 600;
    localparam int END_WAIT   = CAPACITY + 16;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    int          fail_count;
    int          pending;
    int          accepted_in = 0;
    int          idle_cycles = 0;
    bit          offering    = 1'b0;
    bit          hold_done   = 1'b0;
    int          burst_left  = 4;
    logic [31:0] value_pool[16];

    value_set_table_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    value_set_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Accepted input words, used to time the long receiver hold
    always @(posedge clk) begin
        if (in_valid && !in_stall) accepted_in <= accepted_in + 1;
    end

    // Watchdog: too long with no word moving on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Value source: a small pool at the given percentage so that hits happen, otherwise any pattern
    function automatic logic [31:0] pick_value(int pool_pct);
        if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, 15)];
        return $urandom();
    endfunction

    // Offer one word, hold it until taken, then maybe end the burst
    task automatic offer_op(input logic [1:0] mode, input logic [31:0] value);
        t_in_word w;
        w.mode   = mode;
        w.value  = value;
        in_valid <= 1'b1;
        in_word  <= w;
        offering = 1'b1;
        do @(posedge clk); while (in_stall);
        burst_left--;
        if (burst_left <= 0) begin
            in_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Stop offering until every owed word has come back
    task automatic wait_until_answered();
        if (offering) begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge clk); while (pending != 0);
    endtask

    // Random operations with the given mix of insert, remove and lookup percentages
    task automatic run_mix(int n, int ins_pct, int rem_pct, int look_pct);
        int         r;
        logic [1:0] mode;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < ins_pct) mode = MODE_INSERT;
            else if (r < ins_pct + rem_pct) mode = MODE_REMOVE;
            else if (r < ins_pct + rem_pct + look_pct) mode = MODE_LOOKUP;
            else mode = MODE_NOP;
            case (mode)
                MODE_INSERT: offer_op(mode, pick_value(50));
                MODE_REMOVE: offer_op(mode, pick_value(85));
                default:     offer_op(mode, pick_value(60));
            endcase
        end
    endtask

    // Receiver: stall rate changes now and then; one long hold while the sender keeps going
    initial begin : receiver
        int pct;
        int left;
        pct  = 0;
        left = 0;
        forever begin
            @(posedge clk);
            if (!hold_done && accepted_in >= 120) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                if (left == 0) begin
                    case ($urandom_range(0, 3))
                        0: pct = 0;
                        1: pct = 25;
                        2: pct = 50;
                        default: pct = 90;
                    endcase
                    left = $urandom_range(16, 120);
                end
                left--;
                out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h0000_0001;
        for (int k = 4; k < 16; k++) value_pool[k] = $urandom();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, duplicates, shifts on remove, unused mode
        offer_op(MODE_LOOKUP, 32'h0000_0000);
        offer_op(MODE_REMOVE, 32'h1234_5678);
        offer_op(MODE_NOP,    32'h0000_0000);
        offer_op(MODE_INSERT, 32'h0000_0000);
        offer_op(MODE_INSERT, 32'hFFFF_FFFF);
        offer_op(MODE_INSERT, 32'h8000_0000);
        offer_op(MODE_INSERT, 32'hFFFF_FFFF);
        offer_op(MODE_INSERT, 32'h0000_0001);
        offer_op(MODE_LOOKUP, 32'hFFFF_FFFF);
        offer_op(MODE_LOOKUP, 32'h7FFF_FFFF);
        offer_op(MODE_REMOVE, 32'hFFFF_FFFF);
        offer_op(MODE_LOOKUP, 32'hFFFF_FFFF);
        offer_op(MODE_REMOVE, 32'h0000_0000);
        offer_op(MODE_REMOVE, 32'h0000_0001);
        offer_op(MODE_NOP,    32'hFFFF_FFFF);
        offer_op(MODE_REMOVE, 32'hDEAD_BEEF);
        offer_op(MODE_REMOVE, 32'hFFFF_FFFF);
        offer_op(MODE_REMOVE, 32'h8000_0000);
        offer_op(MODE_REMOVE, 32'h8000_0000);
        wait_until_answered();

        // fill past capacity so inserts get dropped, then drain, then a mix
        run_mix(200, 88, 3, 7);
        wait_until_answered();
        run_mix(140, 15, 70, 12);
        run_mix(50, 30, 35, 30);
        wait_until_answered();

        repeat (END_WAIT) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
